[rtl/integer_field_formatter_assert.svh]
// Assertion macros shared by the formatter RTL.
`ifndef INTEGER_FIELD_FORMATTER_ASSERT_SVH
`define INTEGER_FIELD_FORMATTER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define IFF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define IFF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/iff_pkg.sv]
// Types, constants, microprogram and lookup functions of the integer field formatter.
`default_nettype none

package iff_pkg;

    localparam int INT_BITS  = 32;
    localparam int MAX_WIDTH = 63;

    localparam int ACT_W   = 3;
    localparam int VALUE_W = 32;
    localparam int FW_W    = 6;
    localparam int CH_W    = 8;

    localparam logic [VALUE_W-1:0] INT_MASK = VALUE_W'((64'd1 << INT_BITS) - 64'd1);

    // Digit counts of a full 32-bit argument per base.
    localparam logic [FW_W-1:0] DEC_DIGITS = FW_W'(10);
    localparam logic [FW_W-1:0] HEX_DIGITS = FW_W'(8);
    localparam logic [FW_W-1:0] OCT_DIGITS = FW_W'(11);
    localparam logic [FW_W-1:0] BIN_DIGITS = FW_W'(32);

    localparam logic [CH_W-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [CH_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CHAR_SPACE = 8'h20;

    typedef enum logic [ACT_W-1:0] {
        ACT_LITERAL = 3'd0,
        ACT_CHAR    = 3'd1,
        ACT_SDEC    = 3'd2,
        ACT_UDEC    = 3'd3,
        ACT_HEX     = 3'd4,
        ACT_OCT     = 3'd5,
        ACT_BIN     = 3'd6,
        ACT_NONE    = 3'd7
    } t_action;

    // Step addresses of the microprogram.
    typedef enum logic [3:0] {
        PC_FETCH  = 4'd0,
        PC_LIT    = 4'd1,
        PC_DABBLE = 4'd2,
        PC_SKIP   = 4'd3,
        PC_SIZE   = 4'd4,
        PC_LSIGN  = 4'd5,
        PC_PRE    = 4'd6,
        PC_TSIGN  = 4'd7,
        PC_TEXT   = 4'd8,
        PC_POST   = 4'd9
    } t_pc;

    typedef enum logic [3:0] {
        UOP_FETCH,
        UOP_LIT,
        UOP_DABBLE,
        UOP_SKIP,
        UOP_SIZE,
        UOP_LSIGN,
        UOP_PRE,
        UOP_TSIGN,
        UOP_TEXT,
        UOP_POST
    } t_uop;

    typedef struct packed {
        t_uop op;
        t_pc  next;
    } t_uword;

    // Control store: one word per step, next is taken once the step is done.
    function automatic t_uword uprog(input t_pc pc);
        t_uword w;
        unique case (pc)
            PC_FETCH:  w = '{op: UOP_FETCH,  next: PC_FETCH};
            PC_LIT:    w = '{op: UOP_LIT,    next: PC_FETCH};
            PC_DABBLE: w = '{op: UOP_DABBLE, next: PC_SKIP};
            PC_SKIP:   w = '{op: UOP_SKIP,   next: PC_SIZE};
            PC_SIZE:   w = '{op: UOP_SIZE,   next: PC_LSIGN};
            PC_LSIGN:  w = '{op: UOP_LSIGN,  next: PC_PRE};
            PC_PRE:    w = '{op: UOP_PRE,    next: PC_TSIGN};
            PC_TSIGN:  w = '{op: UOP_TSIGN,  next: PC_TEXT};
            PC_TEXT:   w = '{op: UOP_TEXT,   next: PC_POST};
            PC_POST:   w = '{op: UOP_POST,   next: PC_FETCH};
            default:   w = '{op: UOP_FETCH,  next: PC_FETCH};
        endcase
        return w;
    endfunction

    // Entry step per action.
    function automatic t_pc dispatch(input t_action act);
        t_pc pc;
        unique case (act)
            ACT_LITERAL:                pc = PC_LIT;
            ACT_CHAR:                   pc = PC_SIZE;
            ACT_SDEC, ACT_UDEC:         pc = PC_DABBLE;
            ACT_HEX, ACT_OCT, ACT_BIN:  pc = PC_SKIP;
            ACT_NONE:                   pc = PC_FETCH;
            default:                    pc = PC_FETCH;
        endcase
        return pc;
    endfunction

    function automatic logic [CH_W-1:0] digit_char(input logic [3:0] d);
        logic [CH_W-1:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + CH_W'(d);
        end else begin
            c = 8'h61 + CH_W'(d - 4'd10);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/iff_in_if.sv]
// Input channel of the formatter: one literal or conversion request per transfer.
`default_nettype none

interface iff_in_if;
    import iff_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [ACT_W-1:0]      action;
    logic [VALUE_W-1:0]    value;
    logic                  long_arg;
    logic [FW_W-1:0]       width;
    logic                  left_justify;
    logic                  center;
    logic                  zero_fill;

    modport source (
        output valid, action, value, long_arg, width, left_justify, center, zero_fill,
        input  ready
    );

    modport sink (
        input  valid, action, value, long_arg, width, left_justify, center, zero_fill,
        output ready
    );
endinterface

`default_nettype wire

[rtl/iff_out_if.sv]
// Output channel of the formatter: one ASCII character per transfer.
`default_nettype none

interface iff_out_if;
    import iff_pkg::*;

    logic             valid;
    logic             ready;
    logic [CH_W-1:0]  ch;
    logic             last;

    modport source (
        output valid, ch, last,
        input  ready
    );

    modport sink (
        input  valid, ch, last,
        output ready
    );
endinterface

`default_nettype wire

[rtl/integer_field_formatter.sv]
// Integer field formatter: microcoded sequencer that prints one field per request.
//
//  channel | dir | payload                                                    | handshake
//  --------+-----+------------------------------------------------------------+------------
//  i_in    | in  | action value long_arg width left_justify center zero_fill  | valid/ready
//  o_out   | out | ch last                                                    | valid/ready
//
// Steps: a literal is fetched and then emitted; a conversion is fetched, runs the
// double-dabble for decimal, for a number skips the leading zero digits, sizes the field,
// then walks the leading sign, pre-padding, trailing sign, digit text and post-padding
// steps, empty ones included, and prints one output character at a time. The step counter walks one step at a time
// and the output register takes one character per cycle while it is not stalled. Reset clears the step counter
// and the output valid flag. A stalled output register holds the sequencer on its step.
`default_nettype none

`include "integer_field_formatter_assert.svh"

module integer_field_formatter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    iff_in_if.sink     i_in,
    iff_out_if.source  o_out
);
    import iff_pkg::*;

    // Sequencer state.
    t_pc    r_pc, n_pc;
    t_uword uw;

    // Output register.
    logic              r_ov, n_ov;
    logic [CH_W-1:0]   r_ch, n_ch;
    logic              r_last, n_last;

    // Datapath registers, loaded on the request transfer.
    t_action           r_act, n_act;
    logic [CH_W-1:0]   r_byte, n_byte;
    logic [FW_W-1:0]   r_fw, n_fw;
    logic              r_left, n_left;
    logic              r_cent, n_cent;
    logic              r_zero, n_zero;
    logic              r_neg, n_neg;
    logic [39:0]       r_sh, n_sh;      // digit shifter, top digit first; BCD for decimal
    logic [VALUE_W-1:0] r_bin, n_bin;   // binary feed of the double-dabble
    logic [FW_W-1:0]   r_nd, n_nd;      // digits left to print
    logic [4:0]        r_cnt, n_cnt;    // double-dabble step counter
    logic [FW_W-1:0]   r_pre, n_pre;
    logic [FW_W-1:0]   r_post, n_post;

    // Request decode.
    t_action            in_act;
    logic [VALUE_W-1:0] in_mask;
    logic [VALUE_W-1:0] in_v;
    logic               in_sign;
    logic [VALUE_W-1:0] in_mag;
    logic [FW_W-1:0]    in_fw;
    logic               in_fire;

    // Step helpers.
    logic               emit, emit_ok, emit_fire, done;
    logic [CH_W-1:0]    e_ch;
    logic               e_last;
    logic [3:0]         cur_dig;
    logic [39:0]        sh_adv;
    logic [39:0]        bcd_adj;
    logic [CH_W-1:0]    fill_ch;
    logic [FW_W-1:0]    text_len, fw_eff, pad;

    assign uw       = uprog(r_pc);
    assign emit_ok  = !r_ov || o_out.ready;
    assign in_fire  = i_in.valid && i_in.ready;
    assign i_in.ready = (uw.op == UOP_FETCH);

    assign o_out.valid = r_ov;
    assign o_out.ch    = r_ch;
    assign o_out.last  = r_last;

    // Mask short arguments; take the magnitude of a negative signed decimal.
    assign in_act  = t_action'(i_in.action);
    assign in_mask = i_in.long_arg ? {VALUE_W{1'b1}} : INT_MASK;
    assign in_v    = i_in.value & in_mask;
    assign in_sign = (in_act == ACT_SDEC) &&
                     (i_in.long_arg ? in_v[VALUE_W-1] : in_v[INT_BITS-1]);
    assign in_mag  = in_sign ? ((~in_v + VALUE_W'(1)) & in_mask) : in_v;
    assign in_fw   = (i_in.width > FW_W'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH) : i_in.width;

    assign fill_ch = r_zero ? CHAR_ZERO : CHAR_SPACE;

    // Select the top digit and its shift by base.
    always_comb begin
        unique case (r_act)
            ACT_OCT: begin
                cur_dig = {1'b0, r_sh[39:37]};
                sh_adv  = {r_sh[36:0], 3'b000};
            end
            ACT_BIN: begin
                cur_dig = {3'b000, r_sh[39]};
                sh_adv  = {r_sh[38:0], 1'b0};
            end
            default: begin
                cur_dig = r_sh[39:36];
                sh_adv  = {r_sh[35:0], 4'b0000};
            end
        endcase
    end

    // Add three to every BCD digit of five or more before the shift.
    always_comb begin
        for (int k = 0; k < 10; k++) begin
            bcd_adj[4*k +: 4] = (r_sh[4*k +: 4] >= 4'd5) ? r_sh[4*k +: 4] + 4'd3
                                                          : r_sh[4*k +: 4];
        end
    end

    // Field sizing; a leading zero-fill minus takes one place of the width.
    assign text_len = (r_act == ACT_CHAR) ? FW_W'(1) : r_nd + FW_W'(r_neg && !r_zero);
    assign fw_eff   = (r_neg && r_zero && (r_fw != '0)) ? r_fw - FW_W'(1) : r_fw;
    assign pad      = (fw_eff > text_len) ? fw_eff - text_len : '0;

    // Execute the current control word.
    always_comb begin
        n_pc   = r_pc;
        n_act  = r_act;
        n_byte = r_byte;
        n_fw   = r_fw;
        n_left = r_left;
        n_cent = r_cent;
        n_zero = r_zero;
        n_neg  = r_neg;
        n_sh   = r_sh;
        n_bin  = r_bin;
        n_nd   = r_nd;
        n_cnt  = r_cnt;
        n_pre  = r_pre;
        n_post = r_post;
        emit   = 1'b0;
        e_ch   = fill_ch;
        e_last = 1'b0;
        done   = 1'b1;

        unique case (uw.op)
            UOP_FETCH: begin
                done = 1'b0;
                if (in_fire) begin
                    n_pc   = dispatch(in_act);
                    n_act  = in_act;
                    n_byte = i_in.value[CH_W-1:0];
                    n_fw   = in_fw;
                    n_left = i_in.left_justify;
                    n_cent = i_in.center;
                    n_zero = i_in.zero_fill;
                    n_neg  = in_sign;
                    n_bin  = in_mag;
                    n_cnt  = 5'd31;
                    unique case (in_act)
                        ACT_OCT: begin
                            n_sh = {1'b0, in_mag, 7'b0};
                            n_nd = OCT_DIGITS;
                        end
                        ACT_BIN: begin
                            n_sh = {in_mag, 8'b0};
                            n_nd = BIN_DIGITS;
                        end
                        ACT_HEX: begin
                            n_sh = {in_mag, 8'b0};
                            n_nd = HEX_DIGITS;
                        end
                        default: begin
                            n_sh = '0;
                            n_nd = DEC_DIGITS;
                        end
                    endcase
                end
            end
            UOP_LIT: begin
                emit   = 1'b1;
                e_ch   = r_byte;
                e_last = 1'b1;
                done   = emit_ok;
            end
            UOP_DABBLE: begin
                n_sh  = {bcd_adj[38:0], r_bin[VALUE_W-1]};
                n_bin = {r_bin[VALUE_W-2:0], 1'b0};
                n_cnt = r_cnt - 5'd1;
                done  = (r_cnt == '0);
            end
            UOP_SKIP: begin
                // Drop leading zero digits, keep at least one.
                if ((cur_dig == 4'd0) && (r_nd > FW_W'(1))) begin
                    n_sh = sh_adv;
                    n_nd = r_nd - FW_W'(1);
                    done = 1'b0;
                end
            end
            UOP_SIZE: begin
                if (r_cent) begin
                    n_pre  = pad >> 1;
                    n_post = pad - (pad >> 1);
                end else if (r_left) begin
                    n_pre  = '0;
                    n_post = pad;
                end else begin
                    n_pre  = pad;
                    n_post = '0;
                end
            end
            UOP_LSIGN: begin
                if (r_neg && r_zero) begin
                    emit = 1'b1;
                    e_ch = CHAR_MINUS;
                    done = emit_ok;
                end
            end
            UOP_PRE: begin
                if (r_pre != '0) begin
                    emit = 1'b1;
                    done = emit_ok && (r_pre == FW_W'(1));
                    if (emit_ok) begin
                        n_pre = r_pre - FW_W'(1);
                    end
                end
            end
            UOP_TSIGN: begin
                if (r_neg && !r_zero) begin
                    emit = 1'b1;
                    e_ch = CHAR_MINUS;
                    done = emit_ok;
                end
            end
            UOP_TEXT: begin
                emit = 1'b1;
                if (r_act == ACT_CHAR) begin
                    e_ch   = r_byte;
                    e_last = (r_post == '0);
                    done   = emit_ok;
                end else begin
                    e_ch   = digit_char(cur_dig);
                    e_last = (r_nd == FW_W'(1)) && (r_post == '0);
                    done   = emit_ok && (r_nd == FW_W'(1));
                    if (emit_ok) begin
                        n_sh = sh_adv;
                        n_nd = r_nd - FW_W'(1);
                    end
                end
            end
            UOP_POST: begin
                if (r_post != '0) begin
                    emit   = 1'b1;
                    e_last = (r_post == FW_W'(1));
                    done   = emit_ok && (r_post == FW_W'(1));
                    if (emit_ok) begin
                        n_post = r_post - FW_W'(1);
                    end
                end
            end
            default: begin
                done = 1'b1;
            end
        endcase

        if (done) begin
            n_pc = uw.next;
        end
    end

    assign emit_fire = emit && emit_ok;

    // Load the output register on an emitted character, clear it on a bare transfer.
    always_comb begin
        n_ov   = r_ov;
        n_ch   = r_ch;
        n_last = r_last;
        if (emit_fire) begin
            n_ov   = 1'b1;
            n_ch   = e_ch;
            n_last = e_last;
        end else if (o_out.ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_FETCH;
            r_ov <= 1'b0;
        end else begin
            r_pc <= n_pc;
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch   <= n_ch;
        r_last <= n_last;
        r_act  <= n_act;
        r_byte <= n_byte;
        r_fw   <= n_fw;
        r_left <= n_left;
        r_cent <= n_cent;
        r_zero <= n_zero;
        r_neg  <= n_neg;
        r_sh   <= n_sh;
        r_bin  <= n_bin;
        r_nd   <= n_nd;
        r_cnt  <= n_cnt;
        r_pre  <= n_pre;
        r_post <= n_post;
    end

    // A literal request goes straight to its single output step.
    `IFF_ASSERT_NEXT(a_lit_dispatch, i_clk, i_rst_n,
        in_fire && (in_act == ACT_LITERAL), r_pc == PC_LIT,
        "literal request did not dispatch to the literal step")

    // After the final character only the empty tail or the fetch step may follow.
    `IFF_ASSERT_NEXT(a_last_ends_item, i_clk, i_rst_n,
        emit_fire && e_last, (r_pc == PC_FETCH) || ((r_pc == PC_POST) && (r_post == '0)),
        "sequencer kept working after the final character")

    // The digit counter never runs out while digits are printed.
    `IFF_ASSERT_SAME(a_digits_left, i_clk, i_rst_n,
        (r_pc == PC_TEXT) && (r_act != ACT_CHAR), r_nd != '0,
        "digit step entered with no digits left")

    // Back at fetch, any character still waiting closes its item.
    `IFF_ASSERT_SAME(a_fetch_after_last, i_clk, i_rst_n,
        (r_pc == PC_FETCH) && r_ov, r_last,
        "new request taken while the previous item is unfinished")

endmodule

`default_nettype wire
